>>> rtl/gfcc_pkg.sv
// Package for the grid footprint collision checker.
// Holds the shared constants, function and register codes, and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package gfcc_pkg;

	localparam int MAX_COLS_DEF    = 256;
	localparam int MAX_ROWS_DEF    = 256;
	localparam int HALF_SPAN_X_DEF = 7;
	localparam int HALF_SPAN_Y_DEF = 4;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int DIM_W      = 9;
	localparam int CPM_W      = 32;
	localparam int LIMIT_W    = 7;
	localparam int POS_W      = 32;
	localparam int CELL_W     = 8;

	localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 9'd256;
	localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 9'd256;
	localparam logic [CPM_W-1:0]   CPM_RST         = 32'd65536;
	localparam logic [LIMIT_W-1:0] FREE_LIMIT_RST  = 7'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_CPM         = 2'd2,
		REG_FREE_LIMIT  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_MULX,
		ST_MULY,
		ST_CHK,
		ST_SCAN,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

>>> rtl/gfcc_ifs.sv
// Channel interfaces of the grid footprint collision checker.
// gfcc_cmd_if carries command items, gfcc_res_if carries result items; no dependencies.
`timescale 1ns / 1ps

interface gfcc_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [7:0]         cell_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, func, cell_value, pos_x, pos_y, input ready);
	modport sink   (input valid, func, cell_value, pos_x, pos_y, output ready);
endinterface

interface gfcc_res_if;
	logic       valid;
	logic       ready;
	logic       footprint_free;
	logic       status;
	logic       map_complete;
	logic [8:0] free_min_col;
	logic [7:0] free_max_col;
	logic [8:0] free_min_row;
	logic [7:0] free_max_row;

	modport source (output valid, footprint_free, status, map_complete, free_min_col,
		free_max_col, free_min_row, free_max_row, input ready);
	modport sink   (input valid, footprint_free, status, map_complete, free_min_col,
		free_max_col, free_min_row, free_max_row, output ready);
endinterface

>>> rtl/grid_footprint_collision_check.sv
// Top level of the grid footprint collision checker: map memory, loader and window scan.
// Depends on gfcc_pkg and the interfaces in gfcc_ifs.sv.
//
//   channel   dir   handshake     payload
//   cmd       in    valid/ready   func, cell_value, pos_x, pos_y
//   res       out   valid/ready   footprint_free, status, map_complete, free box
//   cfg       in    cfg_wr_en     cfg_index, cfg_data
//
// One item at a time: start, unused codes, ignored loads and early queries go to ST_RESP;
// a load runs the bit-serial row/column divider (ST_DIV) over the LW-bit cell index
// (LW = 17 at 256 by 256), then ST_LOAD; a query runs ST_MULX, ST_MULY and ST_CHK and,
// if its window stays in the map, one map memory read per window cell in ST_SCAN.
// Reset clears the control state; map contents are undefined until loaded.
// A stalled result holds in the output register; the next item is taken, and its result
// waits in ST_RESP with cmd.ready low until the register frees.
`timescale 1ns / 1ps

module grid_footprint_collision_check #(
	parameter int MAX_COLS    = gfcc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS    = gfcc_pkg::MAX_ROWS_DEF,
	parameter int HALF_SPAN_X = gfcc_pkg::HALF_SPAN_X_DEF,
	parameter int HALF_SPAN_Y = gfcc_pkg::HALF_SPAN_Y_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gfcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	gfcc_cmd_if.sink                          cmd,
	gfcc_res_if.source                        res
);
	import gfcc_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int DCW   = $clog2(LW + 1);
	localparam int XLAST = 2 * HALF_SPAN_X;
	localparam int YLAST = 2 * HALF_SPAN_Y;
	localparam int XCW   = $clog2(XLAST + 2);
	localparam int YCW   = $clog2(YLAST + 2);
	localparam int MW_C  = (MAX_COLS > 511) ? 511 : MAX_COLS;
	localparam int MW_R  = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
	localparam logic [DIM_W-1:0] RST_W = (MAX_COLS < 256) ? DIM_W'(MAX_COLS) : GRID_WIDTH_RST;
	localparam logic [DIM_W-1:0] RST_H = (MAX_ROWS < 256) ? DIM_W'(MAX_ROWS) : GRID_HEIGHT_RST;
	localparam logic signed [33:0] HXS = 34'(HALF_SPAN_X);
	localparam logic signed [33:0] HYS = 34'(HALF_SPAN_Y);

	// configuration
	logic [DIM_W-1:0]   grid_width_q;
	logic [DIM_W-1:0]   grid_height_q;
	logic [CPM_W-1:0]   cpm_q;
	logic [LIMIT_W-1:0] free_limit_q;

	// map state
	logic [LW-1:0]      cells_loaded_q;
	logic               grid_ready_q;
	logic [DIM_W-1:0]   box_min_col_q;
	logic [DIM_W-1:0]   box_max_col_q;
	logic [DIM_W-1:0]   box_min_row_q;
	logic [DIM_W-1:0]   box_max_row_q;

	// item registers
	state_t             st_q, st_d;
	logic [1:0]         func_q;
	logic [CELL_W-1:0]  val_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic               ffree_q;
	logic               status_q;

	// divider
	logic [DCW-1:0]     div_cnt_q;
	logic [DIM_W-1:0]   div_rem_q;
	logic [LW-1:0]      div_quo_q;
	logic [DIM_W:0]     div_trial;
	logic               div_bit;

	// query datapath
	logic signed [63:0] prod_q;
	logic signed [64:0] mul_p;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy;
	logic signed [33:0] cx_e, cy_e, w_s, h_s;
	logic               in_range;
	logic [DIM_W-1:0]   col0, row0;
	logic [18:0]        base_full;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      row_addr_q;
	logic [XCW-1:0]     xi_q;
	logic [YCW-1:0]     yi_q;
	logic               rd_valid_s1;
	logic [CELL_W-1:0]  rd_data_s1;
	logic [CELL_W-1:0]  mem [DEPTH];

	// output register
	logic               out_valid_q;
	logic               o_ffree_q, o_status_q, o_complete_q;
	logic [DIM_W-1:0]   o_min_col_q, o_min_row_q;
	logic [7:0]         o_max_col_q, o_max_row_q;

	// derived
	logic [DIM_W-1:0]   eff_w, eff_h;
	logic [17:0]        total_full;
	logic [LW-1:0]      total;
	logic               complete;
	logic               accept;
	logic               out_load;

	always_comb begin
		if (grid_width_q == '0) begin
			eff_w = DIM_W'(1);
		end else if (int'(grid_width_q) > MW_C) begin
			eff_w = DIM_W'(MW_C);
		end else begin
			eff_w = grid_width_q;
		end
		if (grid_height_q == '0) begin
			eff_h = DIM_W'(1);
		end else if (int'(grid_height_q) > MW_R) begin
			eff_h = DIM_W'(MW_R);
		end else begin
			eff_h = grid_height_q;
		end
	end

	assign total_full = eff_w * eff_h;
	assign total      = LW'(total_full);
	assign complete   = grid_ready_q && (cells_loaded_q >= total);
	assign accept     = cmd.valid && cmd.ready;
	assign out_load   = (st_q == ST_RESP) && (!out_valid_q || res.ready);

	assign div_trial = {div_rem_q, div_quo_q[LW-1]};
	assign div_bit   = (div_trial >= {1'b0, eff_w});

	assign mul_p = 65'((st_q == ST_MULX) ? pos_x_q : pos_y_q) * 65'($signed({1'b0, cpm_q}));

	assign cy        = prod_q[63:32];
	assign cx_e      = 34'(cx_q);
	assign cy_e      = 34'(cy);
	assign w_s       = $signed({25'b0, eff_w});
	assign h_s       = $signed({25'b0, eff_h});
	assign in_range  = (cx_e >= HXS) && ((cx_e + HXS) < w_s) &&
		(cy_e >= HYS) && ((cy_e + HYS) < h_s);
	assign col0      = DIM_W'(cx_e - HXS);
	assign row0      = DIM_W'(cy_e - HYS);
	assign base_full = 19'(row0) * 19'(eff_w) + 19'(col0);

	// next state and handshake
	always_comb begin
		st_d      = st_q;
		cmd.ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					unique case (func_t'(cmd.func))
						FUNC_LOAD:  st_d = (cells_loaded_q < total) ? ST_DIV : ST_RESP;
						FUNC_QUERY: st_d = complete ? ST_MULX : ST_RESP;
						FUNC_CLEAR,
						FUNC_NONE:  st_d = ST_RESP;
					endcase
				end
			end
			ST_DIV:   st_d = (div_cnt_q == DCW'(LW - 1)) ? ST_LOAD : ST_DIV;
			ST_LOAD:  st_d = ST_RESP;
			ST_MULX:  st_d = ST_MULY;
			ST_MULY:  st_d = ST_CHK;
			ST_CHK:   st_d = in_range ? ST_SCAN : ST_RESP;
			ST_SCAN: begin
				if ((xi_q == XCW'(XLAST)) && (yi_q == YCW'(YLAST))) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: st_d = ST_RESP;
			ST_RESP:  st_d = out_load ? ST_IDLE : ST_RESP;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			cpm_q         <= CPM_RST;
			free_limit_q  <= FREE_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
				REG_CPM:         cpm_q         <= cfg_data[CPM_W-1:0];
				REG_FREE_LIMIT:  free_limit_q  <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	// map state: start and load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_loaded_q <= '0;
			grid_ready_q   <= 1'b0;
			box_min_col_q  <= RST_W;
			box_max_col_q  <= '0;
			box_min_row_q  <= RST_H;
			box_max_row_q  <= '0;
		end else if (accept && (func_t'(cmd.func) == FUNC_CLEAR)) begin
			cells_loaded_q <= '0;
			grid_ready_q   <= 1'b0;
			box_min_col_q  <= eff_w;
			box_max_col_q  <= '0;
			box_min_row_q  <= eff_h;
			box_max_row_q  <= '0;
		end else if (st_q == ST_LOAD) begin
			if (val_q <= {1'b0, free_limit_q}) begin
				if (div_rem_q < box_min_col_q) box_min_col_q <= div_rem_q;
				if (div_rem_q > box_max_col_q) box_max_col_q <= div_rem_q;
				if (div_quo_q[DIM_W-1:0] < box_min_row_q) box_min_row_q <= div_quo_q[DIM_W-1:0];
				if (div_quo_q[DIM_W-1:0] > box_max_row_q) box_max_row_q <= div_quo_q[DIM_W-1:0];
			end
			cells_loaded_q <= cells_loaded_q + LW'(1);
			if ((cells_loaded_q + LW'(1)) >= total) grid_ready_q <= 1'b1;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				func_q   <= cmd.func;
				val_q    <= cmd.cell_value;
				pos_x_q  <= cmd.pos_x;
				pos_y_q  <= cmd.pos_y;
				ffree_q  <= 1'b0;
				status_q <= (func_t'(cmd.func) == FUNC_QUERY) && !complete;
				div_cnt_q <= '0;
				div_rem_q <= '0;
				div_quo_q <= cells_loaded_q;
			end
			ST_DIV: begin
				div_rem_q <= div_bit ? DIM_W'(div_trial - {1'b0, eff_w}) : div_trial[DIM_W-1:0];
				div_quo_q <= {div_quo_q[LW-2:0], div_bit};
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			ST_MULX: prod_q <= mul_p[63:0];
			ST_MULY: begin
				cx_q   <= prod_q[63:32];
				prod_q <= mul_p[63:0];
			end
			ST_CHK: begin
				ffree_q    <= in_range;
				addr_q     <= AW'(base_full);
				row_addr_q <= AW'(base_full);
				xi_q       <= '0;
				yi_q       <= '0;
			end
			ST_SCAN: begin
				if (xi_q == XCW'(XLAST)) begin
					xi_q       <= '0;
					yi_q       <= yi_q + YCW'(1);
					row_addr_q <= row_addr_q + AW'(eff_w);
					addr_q     <= row_addr_q + AW'(eff_w);
				end else begin
					xi_q   <= xi_q + XCW'(1);
					addr_q <= addr_q + AW'(1);
				end
			end
			default: ;
		endcase
		// drop the window on any occupied known cell
		if (rd_valid_s1 && !rd_data_s1[CELL_W-1] && (rd_data_s1[CELL_W-2:0] > free_limit_q)) begin
			ffree_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (st_q == ST_SCAN);
		end
	end

	// map memory
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD) begin
			mem[cells_loaded_q[AW-1:0]] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_SCAN) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_ffree_q    <= ffree_q && (func_t'(func_q) == FUNC_QUERY);
			o_status_q   <= status_q;
			o_complete_q <= complete;
			o_min_col_q  <= box_min_col_q;
			o_max_col_q  <= box_max_col_q[7:0];
			o_min_row_q  <= box_min_row_q;
			o_max_row_q  <= box_max_row_q[7:0];
		end
	end

	assign res.valid          = out_valid_q;
	assign res.footprint_free = o_ffree_q;
	assign res.status         = o_status_q;
	assign res.map_complete   = o_complete_q;
	assign res.free_min_col   = o_min_col_q;
	assign res.free_max_col   = o_max_col_q;
	assign res.free_min_row   = o_min_row_q;
	assign res.free_max_row   = o_max_row_q;

endmodule

>>> rtl/gfcc_checker.sv
// Port-level checker for the grid footprint collision checker, and its bind.
// Depends on grid_footprint_collision_check and the interfaces in gfcc_ifs.sv.
`timescale 1ns / 1ps

module gfcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_footprint_free,
	input logic       res_status,
	input logic       res_map_complete,
	input logic [8:0] res_free_min_col,
	input logic [7:0] res_free_max_col
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_footprint_free) && $stable(res_status) &&
			$stable(res_free_min_col) && $stable(res_free_max_col))
		else $error("stalled result item changed");

	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status |-> !res_footprint_free)
		else $error("free footprint reported with not-ready status");

	a_free_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_footprint_free |-> res_map_complete)
		else $error("free footprint reported on an incomplete map");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second item taken while one is in work");

endmodule

bind grid_footprint_collision_check gfcc_checker u_gfcc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_footprint_free (res.footprint_free),
	.res_status         (res.status),
	.res_map_complete   (res.map_complete),
	.res_free_min_col   (res.free_min_col),
	.res_free_max_col   (res.free_max_col)
);
